/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is asserted.
`define BCX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define BCX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bcx_pkg.sv */
// Shared types, command codes and default sizes for the binary 3x3 conv unit.
// No dependencies.
package bcx_pkg;

  localparam int IMG_WIDTH_DEF    = 12;
  localparam int IMG_HEIGHT_DEF   = 12;
  localparam int IN_CHANNELS_DEF  = 16;
  localparam int OUT_CHANNELS_DEF = 16;

  localparam int CH_MAX = 16;  // channel lanes carried by the payload
  localparam int TAPS   = 9;
  localparam int DIM_W  = 6;   // holds any row or column up to 63
  localparam int TAG_W  = 4;   // output channel tag

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_THRESH = 2'd1;
  localparam logic [1:0] CMD_PIXEL  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  index;
    logic [8:0]  weight_bits;
    logic [15:0] threshold_word;
    logic [15:0] pixel_bits;
    logic        last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_bits;
    logic [3:0]  out_row;
    logic [3:0]  out_col;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic             wr_weight;
    logic             wr_thresh;
    logic             shift_px;
    logic             shift_zero;
    logic             issue;
    logic [TAG_W-1:0] issue_oc;
    logic             load;
    logic             load_last;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic bits_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/bcx_ctrl.sv */
// Controller: input handshake, position counters, flush sequencing, channel issue.
// Depends on bcx_pkg.
module bcx_ctrl #(
  parameter int IMG_WIDTH    = bcx_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT   = bcx_pkg::IMG_HEIGHT_DEF,
  parameter int OUT_CHANNELS = bcx_pkg::OUT_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  input  logic              in_last,
  output logic              in_stall,
  input  bcx_pkg::dp_stat_t stat,
  output bcx_pkg::dp_cmd_t  cmd
);

  localparam int MAP   = IMG_WIDTH * IMG_HEIGHT;
  localparam int POS_W = $clog2(MAP + 1);
  localparam int PIX_W = $clog2(IMG_WIDTH + 2);
  localparam int FC_W  = $clog2(IMG_WIDTH + 1);
  localparam int ROW_W = $clog2(IMG_HEIGHT);
  localparam int COL_W = $clog2(IMG_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_ISSUE = 5'b00100,
    S_WAIT  = 5'b01000,
    S_LOAD  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [PIX_W-1:0]          pix_r, pix_nxt;
  logic [POS_W-1:0]          opos_r, opos_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [FC_W-1:0]           fcnt_r, fcnt_nxt;
  logic                      fin_r, fin_nxt;
  logic                      flush_r, flush_nxt;
  logic [bcx_pkg::TAG_W-1:0] oc_r, oc_nxt;
  logic                      accept;
  logic                      at_end;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  // no more results in this step after the current one
  assign at_end   = (opos_r == POS_W'(MAP - 1)) ||
                    (flush_r && (fcnt_r == FC_W'(IMG_WIDTH)));

  always_comb begin
    state_nxt = state_r;
    pix_nxt   = pix_r;
    opos_nxt  = opos_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    fcnt_nxt  = fcnt_r;
    fin_nxt   = fin_r;
    flush_nxt = flush_r;
    oc_nxt    = oc_r;
    cmd       = '0;
    cmd.row   = bcx_pkg::DIM_W'(row_r);
    cmd.col   = bcx_pkg::DIM_W'(col_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            bcx_pkg::CMD_WEIGHT: cmd.wr_weight = 1'b1;
            bcx_pkg::CMD_THRESH: cmd.wr_thresh = 1'b1;
            bcx_pkg::CMD_PIXEL: begin
              cmd.shift_px = 1'b1;
              fin_nxt      = in_last;
              flush_nxt    = 1'b0;
              fcnt_nxt     = '0;
              if (pix_r != PIX_W'(IMG_WIDTH + 1)) begin
                pix_nxt = pix_r + PIX_W'(1);
              end
              if ((pix_r == PIX_W'(IMG_WIDTH + 1)) && (opos_r != POS_W'(MAP))) begin
                state_nxt = S_ISSUE;
                oc_nxt    = '0;
              end else if (in_last) begin
                if (opos_r != POS_W'(MAP)) begin
                  state_nxt = S_SHIFT;
                  flush_nxt = 1'b1;
                end else begin
                  pix_nxt  = '0;
                  opos_nxt = '0;
                  row_nxt  = '0;
                  col_nxt  = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift_zero = 1'b1;
        state_nxt      = S_ISSUE;
        oc_nxt         = '0;
      end
      S_ISSUE: begin
        cmd.issue    = 1'b1;
        cmd.issue_oc = oc_r;
        if (oc_r == bcx_pkg::TAG_W'(OUT_CHANNELS - 1)) begin
          state_nxt = S_WAIT;
        end else begin
          oc_nxt = oc_r + bcx_pkg::TAG_W'(1);
        end
      end
      S_WAIT: begin
        if (stat.bits_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load      = 1'b1;
          cmd.load_last = fin_r && at_end;
          opos_nxt      = opos_r + POS_W'(1);
          if (col_r == COL_W'(IMG_WIDTH - 1)) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          if (!fin_r) begin
            state_nxt = S_IDLE;
          end else if (!at_end) begin
            state_nxt = S_SHIFT;
            flush_nxt = 1'b1;
            fcnt_nxt  = flush_r ? (fcnt_r + FC_W'(1)) : '0;
          end else begin
            state_nxt = S_IDLE;
            flush_nxt = 1'b0;
            pix_nxt   = '0;
            opos_nxt  = '0;
            row_nxt   = '0;
            col_nxt   = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pix_r   <= '0;
      opos_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      fcnt_r  <= '0;
      fin_r   <= 1'b0;
      flush_r <= 1'b0;
      oc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pix_r   <= pix_nxt;
      opos_r  <= opos_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      fcnt_r  <= fcnt_nxt;
      fin_r   <= fin_nxt;
      flush_r <= flush_nxt;
      oc_r    <= oc_nxt;
    end
  end

endmodule

/* rtl/bcx_dp.sv */
// Datapath: weight/threshold stores, line buffers, 3x3 window, xnor-popcount pipe,
// output register. Depends on bcx_pkg.
module bcx_dp #(
  parameter int IMG_WIDTH    = bcx_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT   = bcx_pkg::IMG_HEIGHT_DEF,
  parameter int IN_CHANNELS  = bcx_pkg::IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = bcx_pkg::OUT_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bcx_pkg::in_item_t  in_data,
  input  bcx_pkg::dp_cmd_t   cmd,
  output bcx_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output bcx_pkg::out_item_t out_data
);

  localparam int LINE_LEN = 2 * IMG_WIDTH;
  localparam int OC_AW    = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int ROW_BITS = IN_CHANNELS * bcx_pkg::TAPS;

  // weight row per output channel, lane ic holds its 9 tap bits
  logic [ROW_BITS-1:0]      wmem [OUT_CHANNELS];
  logic [15:0]              tmem [OUT_CHANNELS];

  logic [IN_CHANNELS-1:0]   rb_r  [LINE_LEN];
  logic [IN_CHANNELS-1:0]   win_r [bcx_pkg::TAPS];
  logic [IN_CHANNELS-1:0]   px;
  logic                     do_shift;

  logic                     w_ok, t_ok;
  logic [OC_AW-1:0]         waddr, taddr;
  logic [3:0]               wlane;

  logic [bcx_pkg::TAPS-1:0] pad;
  logic [2:0]               pad_row, pad_col;

  logic                      v0_r, v1_r, v2_r, done_r;
  logic [bcx_pkg::TAG_W-1:0] oc0_r, oc1_r, oc2_r;
  logic [ROW_BITS-1:0]       wrow_r;
  logic [15:0]               thr0_r, thr1_r, thr2_r;
  logic [3:0]                pop_r   [bcx_pkg::CH_MAX];
  logic [3:0]                pop_nxt [bcx_pkg::CH_MAX];
  logic [7:0]                acc_r, acc_nxt;
  logic                      hit;
  logic [15:0]               bits_r, bits_nxt;

  bcx_pkg::out_item_t        out_r;
  logic                      out_valid_r;

  // ---- stores ----
  assign w_ok  = (int'(in_data.index[7:4]) < OUT_CHANNELS) &&
                 (int'(in_data.index[3:0]) < IN_CHANNELS);
  assign t_ok  = int'(in_data.index) < OUT_CHANNELS;
  assign waddr = in_data.index[4 +: OC_AW];
  assign taddr = in_data.index[OC_AW-1:0];
  assign wlane = in_data.index[3:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_weight && w_ok) begin
      wmem[waddr][wlane*bcx_pkg::TAPS +: bcx_pkg::TAPS] <= in_data.weight_bits;
    end
    if (cmd.issue) begin
      wrow_r <= wmem[cmd.issue_oc[OC_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_thresh && t_ok) begin
      tmem[taddr] <= in_data.threshold_word;
    end
    if (cmd.issue) begin
      thr0_r <= tmem[cmd.issue_oc[OC_AW-1:0]];
    end
  end

  // ---- line buffers and window ----
  assign do_shift = cmd.shift_px || cmd.shift_zero;
  assign px       = cmd.shift_px ? in_data.pixel_bits[IN_CHANNELS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        rb_r[i] <= '0;
      end
      for (int t = 0; t < bcx_pkg::TAPS; t++) begin
        win_r[t] <= '0;
      end
    end else if (do_shift) begin
      rb_r[0] <= px;
      for (int i = 1; i < LINE_LEN; i++) begin
        rb_r[i] <= rb_r[i-1];
      end
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= rb_r[LINE_LEN-1];
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= rb_r[IMG_WIDTH-1];
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= px;
    end
  end

  // ---- padding: taps outside the map read as zero ----
  always_comb begin
    pad_row[0] = (cmd.row == '0);
    pad_row[1] = 1'b0;
    pad_row[2] = (cmd.row == bcx_pkg::DIM_W'(IMG_HEIGHT - 1));
    pad_col[0] = (cmd.col == '0);
    pad_col[1] = 1'b0;
    pad_col[2] = (cmd.col == bcx_pkg::DIM_W'(IMG_WIDTH - 1));
    for (int tr = 0; tr < 3; tr++) begin
      for (int tc = 0; tc < 3; tc++) begin
        pad[tr*3+tc] = pad_row[tr] | pad_col[tc];
      end
    end
  end

  // ---- stage 1: xnor and per-lane 9-bit popcount ----
  always_comb begin
    logic b;
    logic agree;
    for (int ic = 0; ic < bcx_pkg::CH_MAX; ic++) begin
      pop_nxt[ic] = '0;
    end
    for (int ic = 0; ic < IN_CHANNELS; ic++) begin
      for (int t = 0; t < bcx_pkg::TAPS; t++) begin
        b           = pad[t] ? 1'b0 : win_r[t][ic];
        agree       = ~(b ^ wrow_r[ic*bcx_pkg::TAPS + (bcx_pkg::TAPS - 1 - t)]);
        pop_nxt[ic] = pop_nxt[ic] + 4'(agree);
      end
    end
  end

  // ---- stage 2: adder tree over lanes ----
  always_comb begin
    logic [4:0] l1 [8];
    logic [5:0] l2 [4];
    logic [6:0] l3 [2];
    for (int i = 0; i < 8; i++) begin
      l1[i] = 5'(pop_r[2*i]) + 5'(pop_r[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = 6'(l1[2*i]) + 6'(l1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = 7'(l2[2*i]) + 7'(l2[2*i+1]);
    end
    acc_nxt = 8'(l3[0]) + 8'(l3[1]);
  end

  // ---- stage 3: threshold compare, collect channel bits ----
  assign hit = thr2_r[15] ? (15'(acc_r) >= thr2_r[14:0]) : (15'(acc_r) <= thr2_r[14:0]);

  always_comb begin
    bits_nxt = bits_r;
    if (v2_r) begin
      if (oc2_r == '0) begin
        bits_nxt = '0;
      end
      bits_nxt[oc2_r] = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v0_r   <= cmd.issue;
      v1_r   <= v0_r;
      v2_r   <= v1_r;
      done_r <= v2_r && (oc2_r == bcx_pkg::TAG_W'(OUT_CHANNELS - 1));
    end
  end

  always_ff @(posedge clk) begin
    oc0_r  <= cmd.issue_oc;
    oc1_r  <= oc0_r;
    oc2_r  <= oc1_r;
    thr1_r <= thr0_r;
    thr2_r <= thr1_r;
    pop_r  <= pop_nxt;
    acc_r  <= acc_nxt;
    bits_r <= bits_nxt;
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.out_bits <= bits_r;
      out_r.out_row  <= 4'(cmd.row);
      out_r.out_col  <= 4'(cmd.col);
      out_r.last     <= cmd.load_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.bits_done = done_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

/* rtl/binary_conv3x3_xnor_popcount_unit.sv */
// Binary 3x3 same-padded convolution, xnor-popcount over input channels.
// A pixel that completes a window gets its result once the controller has issued every
// output channel in turn through the weight read, three pipe stages, done flag and load.
// The input stalls while such a pixel is in flight and while a last pixel flushes the
// pending positions; other items pass without a stall. Output stalls add to both.
// Reset (rst_n low, synchronous) clears control, line buffers and window, not the stores.
module binary_conv3x3_xnor_popcount_unit #(
  parameter int IMG_WIDTH    = bcx_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT   = bcx_pkg::IMG_HEIGHT_DEF,
  parameter int IN_CHANNELS  = bcx_pkg::IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = bcx_pkg::OUT_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bcx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bcx_pkg::out_item_t out_data
);

  // Commands: weight write (index = out_ch*16 + in_ch), threshold write
  // (index = out_ch, bit 15 picks >= or <=), pixel. Pixels run in raster order;
  // output position o goes out once pixel o+IMG_WIDTH+1 is in, and a pixel
  // marked last pushes zero pixels to drain the positions still pending.

  bcx_pkg::dp_cmd_t  cmd;
  bcx_pkg::dp_stat_t stat;

  // controller: accepts a transfer only when idle, sequences channels and flush
  bcx_ctrl #(
    .IMG_WIDTH    (IMG_WIDTH),
    .IMG_HEIGHT   (IMG_HEIGHT),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_last  (in_data.last_pixel),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: stores, window, popcount pipe, output register
  bcx_dp #(
    .IMG_WIDTH    (IMG_WIDTH),
    .IMG_HEIGHT   (IMG_HEIGHT),
    .IN_CHANNELS  (IN_CHANNELS),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/bcx_checker.sv */
// Port-level checks for the binary 3x3 conv unit, bound to the top level.
// Depends on bcx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcx_checker #(
  parameter int OUT_CHANNELS = bcx_pkg::OUT_CHANNELS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bcx_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bcx_pkg::out_item_t out_data
);

  `BCX_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_data)), "stalled result changed")
  `BCX_ASSERT(a_cfg_idle, clk, rst_n, ((in_valid && !in_stall && (in_data.command != bcx_pkg::CMD_PIXEL)) |=> !in_stall), "load command left the unit busy")
  `BCX_ASSERT_ALWAYS(a_reset_idle, clk, (!rst_n |=> !out_valid && !in_stall), "unit not idle after reset")
  `BCX_ASSERT(a_unused_bits, clk, rst_n, (out_valid |-> ((out_data.out_bits >> OUT_CHANNELS) == 16'd0)), "unused output channel bit set")

endmodule

bind binary_conv3x3_xnor_popcount_unit bcx_checker #(
  .OUT_CHANNELS (OUT_CHANNELS)
) u_bcx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* dv/binary_conv3x3_xnor_popcount_unit_tb.sv */
// Self-checking testbench for binary_conv3x3_xnor_popcount_unit: random bursty stimulus,
// a built-in predictor of the 3x3 xnor-popcount convolution, in-order result checking.
// Depends on bcx_pkg (payload structs, command codes, default sizes) and the unit itself.
module binary_conv3x3_xnor_popcount_unit_tb;

  // Map geometry follows the unit's defaults.
  localparam int W        = bcx_pkg::IMG_WIDTH_DEF;
  localparam int H        = bcx_pkg::IMG_HEIGHT_DEF;
  localparam int IC       = bcx_pkg::IN_CHANNELS_DEF;
  localparam int OC       = bcx_pkg::OUT_CHANNELS_DEF;
  localparam int MAP_SIZE = W * H;
  localparam int LINE_LEN = 2 * W;
  localparam logic [15:0] CH_MASK = (IC >= 16) ? 16'hFFFF : 16'((1 << IC) - 1);

  // Command 3 has no meaning; the unit must drop it.
  localparam logic [1:0] CMD_NONE = 2'd3;

  // The limit leaves ample margin over the slowest legal run.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 4 * (OC + 6);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bcx_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bcx_pkg::out_item_t out_data;

  binary_conv3x3_xnor_popcount_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: weight/threshold stores, line buffers, 3x3 window, counters.
  // ---------------------------------------------------------------------------
  logic [8:0]  wt_mem   [256];
  logic [15:0] thr_mem  [16];
  logic [15:0] line_buf [LINE_LEN];
  logic [15:0] win_reg  [9];        // row-major, top-left first
  int          px_count;
  int          out_pos;

  // Expected convolution outputs, oldest first.
  bcx_pkg::out_item_t conv_expected_q[$];

  // Stimulus waiting to be driven; a set pause flag holds that item back until
  // every expected output has drained.
  bcx_pkg::in_item_t  pending_items[$];
  bit                 pending_pause[$];

  int errors         = 0;
  int transfers_in   = 0;
  int results_seen   = 0;
  int maps_queued    = 0;
  int pixels_queued  = 0;
  int cycle_cnt      = 0;

  initial begin
    for (int i = 0; i < LINE_LEN; i++) line_buf[i] = '0;
    for (int i = 0; i < 9; i++) win_reg[i] = '0;
    for (int i = 0; i < 256; i++) wt_mem[i] = '0;
    for (int i = 0; i < 16; i++) thr_mem[i] = '0;
    px_count = 0;
    out_pos  = 0;
  end

  // Push one pixel through the line buffers into the window.
  task automatic shift_window(input logic [15:0] px);
    logic [15:0] mid_tap;
    logic [15:0] top_tap;
    mid_tap = line_buf[W-1];
    top_tap = line_buf[LINE_LEN-1];
    win_reg[0] = win_reg[1]; win_reg[1] = win_reg[2]; win_reg[2] = top_tap;
    win_reg[3] = win_reg[4]; win_reg[4] = win_reg[5]; win_reg[5] = mid_tap;
    win_reg[6] = win_reg[7]; win_reg[7] = win_reg[8]; win_reg[8] = px;
    for (int i = LINE_LEN - 1; i > 0; i--) line_buf[i] = line_buf[i-1];
    line_buf[0] = px;
  endtask

  // Compute the output at out_pos from the current window and queue it.
  task automatic predict_position(input bit is_last);
    int                 row;
    int                 col;
    int                 acc;
    bit                 pad;
    logic [8:0]         taps;
    logic [8:0]         agree;
    logic [15:0]        tw;
    bcx_pkg::out_item_t res;
    row = out_pos / W;
    col = out_pos % W;
    res = '0;
    for (int oc = 0; oc < OC; oc++) begin
      acc = 0;
      for (int ic = 0; ic < IC; ic++) begin
        taps = '0;
        for (int t = 0; t < 9; t++) begin
          // taps that fall outside the map read as zero, yet still get xnor'ed
          pad = ((t / 3 == 0) && (row == 0)) || ((t / 3 == 2) && (row == H - 1)) ||
                ((t % 3 == 0) && (col == 0)) || ((t % 3 == 2) && (col == W - 1));
          if (!pad) taps[8-t] = win_reg[t][ic];
        end
        agree = ~(taps ^ wt_mem[(oc * 16 + ic) & 255]);
        acc += $countones(agree);
      end
      tw = thr_mem[oc & 15];
      if (tw[15] ? (acc >= int'(tw[14:0])) : (acc <= int'(tw[14:0])))
        res.out_bits[oc] = 1'b1;
    end
    res.out_row = row[3:0];
    res.out_col = col[3:0];
    res.last    = is_last;
    conv_expected_q.push_back(res);
    out_pos++;
  endtask

  // Apply one accepted input transfer to the predictor.
  task automatic conv_model_step(input bcx_pkg::in_item_t it);
    int  prev_px;
    bit  emit_now;
    int  remain;
    int  flush_n;
    case (it.command)
      bcx_pkg::CMD_WEIGHT: wt_mem[it.index] = it.weight_bits;
      bcx_pkg::CMD_THRESH: if (it.index < 16) thr_mem[it.index[3:0]] = it.threshold_word;
      bcx_pkg::CMD_PIXEL: begin
        prev_px = px_count;
        shift_window(it.pixel_bits & CH_MASK);
        if (px_count < 16'hFFFF) px_count++;
        // position o is ready once pixel o+W+1 has arrived
        emit_now = (prev_px >= W + 1) && (out_pos < MAP_SIZE);
        flush_n  = 0;
        if (it.last_pixel) begin
          remain  = MAP_SIZE - out_pos - (emit_now ? 1 : 0);
          flush_n = (remain < W + 1) ? remain : W + 1;
        end
        if (emit_now) predict_position(it.last_pixel && (flush_n == 0));
        // flush: zero pixels shifted in, one output per pending position
        for (int k = 0; k < flush_n; k++) begin
          shift_window('0);
          predict_position(k == flush_n - 1);
        end
        if (it.last_pixel) begin
          px_count = 0;
          out_pos  = 0;
        end
      end
      default: ;  // unknown command: dropped
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------
  task automatic push_item(input bcx_pkg::in_item_t it, input bit pause);
    pending_items.push_back(it);
    pending_pause.push_back(pause);
  endtask

  // Every field random; callers override what matters for the command.
  function automatic bcx_pkg::in_item_t rand_item(input logic [1:0] cmd);
    bcx_pkg::in_item_t it;
    it.command        = cmd;
    it.index          = 8'($urandom_range(0, 255));
    it.weight_bits    = 9'($urandom_range(0, 511));
    it.threshold_word = 16'($urandom_range(0, 65535));
    it.pixel_bits     = 16'($urandom_range(0, 65535));
    it.last_pixel     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Thresholds mostly near the middle of the 0..144 sum range so outputs toggle.
  function automatic logic [15:0] rand_threshold();
    logic [15:0] tw;
    tw[15] = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) tw[14:0] = 15'($urandom_range(0, 32767));
    else tw[14:0] = 15'($urandom_range(40, 104));
    return tw;
  endfunction

  task automatic push_weight(input int idx, input logic [8:0] bits, input bit pause);
    bcx_pkg::in_item_t it;
    it             = rand_item(bcx_pkg::CMD_WEIGHT);
    it.index       = 8'(idx);
    it.weight_bits = bits;
    push_item(it, pause);
  endtask

  task automatic push_threshold(input int idx, input logic [15:0] tw, input bit pause);
    bcx_pkg::in_item_t it;
    it                = rand_item(bcx_pkg::CMD_THRESH);
    it.index          = 8'(idx);
    it.threshold_word = tw;
    push_item(it, pause);
  endtask

  // One map of len pixels in raster order, optional last flag on the final one.
  task automatic queue_map(input int len, input bit close, input bit pause_first);
    bcx_pkg::in_item_t it;
    int                sel;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) push_item(rand_item(CMD_NONE), 1'b0);
      it  = rand_item(bcx_pkg::CMD_PIXEL);
      sel = $urandom_range(0, 15);
      if (sel == 0) it.pixel_bits = '0;
      else if (sel == 1) it.pixel_bits = '1;
      it.last_pixel = close && (i == len - 1);
      push_item(it, pause_first && (i == 0));
    end
    maps_queued++;
    pixels_queued += len;
  endtask

  // Rewrite some weights and thresholds between maps, once the unit has drained.
  task automatic queue_reload(input int n_w, input int n_t);
    int idx;
    for (int i = 0; i < n_w; i++)
      push_weight($urandom_range(0, 255), 9'($urandom_range(0, 511)), i == 0);
    for (int i = 0; i < n_t; i++) begin
      idx = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 15);
      push_threshold(idx, rand_threshold(), (n_w == 0) && (i == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps; payload held while stalled.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_in
    bcx_pkg::in_item_t done_item;
    bit                done_pause;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        conv_model_step(pending_items[0]);
        done_item  = pending_items.pop_front();
        done_pause = pending_pause.pop_front();
        transfers_in++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_pause[0] && conv_expected_q.size() != 0) begin
          in_valid <= 1'b0;  // hold off until the unit has emptied
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_items[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each output transfer, and drive a stall pattern that switches
  // between free flow, random stalls, sparse stalls and long solid stalls.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_run  = 0;

  always @(posedge clk) begin : watch_out
    bcx_pkg::out_item_t want;
    logic               stall_nxt;
    if (rst_n && out_valid && !out_stall) begin
      if (conv_expected_q.size() == 0) begin
        $error("output transfer with nothing expected: bits %h row %0d col %0d last %0d",
               out_data.out_bits, out_data.out_row, out_data.out_col, out_data.last);
        errors++;
      end else begin
        want = conv_expected_q.pop_front();
        results_seen++;
        if (out_data.out_bits !== want.out_bits) begin
          $error("out_bits mismatch: expected %h, got %h", want.out_bits, out_data.out_bits);
          errors++;
        end
        if (out_data.out_row !== want.out_row) begin
          $error("out_row mismatch: expected %0d, got %0d", want.out_row, out_data.out_row);
          errors++;
        end
        if (out_data.out_col !== want.out_col) begin
          $error("out_col mismatch: expected %0d, got %0d", want.out_col, out_data.out_col);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
      end
    end
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(1, 40);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0:       stall_nxt = 1'b0;
      1:       stall_nxt = 1'($urandom_range(0, 1));
      2:       stall_nxt = 1'b1;
      default: stall_nxt = ($urandom_range(0, 3) == 0);
    endcase
    out_stall <= rst_n ? stall_nxt : 1'b0;
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[binary_conv3x3_xnor_popcount_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    bcx_pkg::in_item_t it;

    // Full load of both stores: no pixel may read an unwritten entry.
    for (int i = 0; i < 256; i++) begin
      if (i == 0) push_weight(i, 9'h000, 1'b0);
      else if (i == 255) push_weight(i, 9'h1FF, 1'b0);
      else push_weight(i, 9'($urandom_range(0, 511)), 1'b0);
    end
    for (int i = 0; i < 16; i++) push_threshold(i, rand_threshold(), 1'b0);

    // Directed corners.
    it = '1;
    it.command = CMD_NONE;               // unknown command, all other bits set
    push_item(it, 1'b0);
    push_threshold(16, 16'hFFFF, 1'b0);  // out-of-range threshold indexes
    push_threshold(255, 16'h0000, 1'b0);
    push_threshold(0, 16'hFFFF, 1'b0);   // >= 0x7FFF: never set
    push_threshold(1, 16'h7FFF, 1'b0);   // <= 0x7FFF: always set
    push_threshold(2, 16'h8000, 1'b0);   // >= 0: always set
    push_threshold(15, 16'h0000, 1'b0);  // <= 0
    push_threshold(3, {1'b1, 15'd72}, 1'b0);
    push_threshold(4, {1'b0, 15'd72}, 1'b0);
    push_weight(0, 9'h1FF, 1'b0);
    push_weight(255, 9'h000, 1'b0);
    // single all-ones pixel closing the map at once: whole flush from zeros
    it = bcx_pkg::in_item_t'(rand_item(bcx_pkg::CMD_PIXEL));
    it.pixel_bits = '1;
    it.last_pixel = 1'b1;
    push_item(it, 1'b0);
    // all-zero pixel, same early close, held until the unit has drained
    it = rand_item(bcx_pkg::CMD_PIXEL);
    it.pixel_bits = '0;
    it.last_pixel = 1'b1;
    push_item(it, 1'b1);
    // early close after a few emitted positions: the most outputs from one transfer
    queue_map(W + 4, 1'b1, 1'b0);

    // A few rewrites once drained, then one complete map with bottom-row padding.
    queue_reload(2, 2);
    queue_map(MAP_SIZE, 1'b1, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (conv_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers over %0d maps (%0d pixels), %0d outputs checked.",
             transfers_in, maps_queued, pixels_queued, results_seen);
    if (errors == 0 && conv_expected_q.size() == 0) begin
      $display("[binary_conv3x3_xnor_popcount_unit] OK");
    end else begin
      $display("[binary_conv3x3_xnor_popcount_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bcx_pkg.sv
rtl/bcx_ctrl.sv
rtl/bcx_dp.sv
rtl/binary_conv3x3_xnor_popcount_unit.sv
rtl/bcx_checker.sv
dv/binary_conv3x3_xnor_popcount_unit_tb.sv
